// ===== hdl/npb_pkg.sv =====
`default_nettype none

package npb_pkg;

	localparam int unsigned MAX_PIXELS = 16384;
	localparam int unsigned PIX_W      = 15;

	typedef logic [PIX_W-1:0] pix_cnt_t;

	typedef enum logic [1:0] {
		PH_CTRL    = 2'd0,
		PH_REPEAT  = 2'd1,
		PH_LITERAL = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_VALUE    = 3'd1,
		ST_OVERFLOW = 3'd2,
		ST_TRUNC    = 3'd3,
		ST_SHORT    = 3'd4
	} status_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] literal_left;
		logic [7:0] repeat_count;
		pix_cnt_t   pixels_done;
		logic       dropping;
		status_t    first_error;
	} dec_state_t;

	typedef struct packed {
		logic [3:0] pixel_value;
		logic [7:0] run_length;
		logic       bitmap_done;
		status_t    status;
	} result_t;

	localparam dec_state_t STATE_CLEAR = '{
		phase:        PH_CTRL,
		literal_left: 8'd0,
		repeat_count: 8'd0,
		pixels_done:  '0,
		dropping:     1'b0,
		first_error:  ST_OK
	};

endpackage

`default_nettype wire

// ===== hdl/nibble_packbits_decoder.sv =====
`default_nettype none

// Channel  Handshake            Payload
// ------   -------------------  ---------------------------------------------
// in       in_valid/in_stall    code_byte[7:0], end_of_bitmap
// out      out_valid/out_stall  pixel_value[3:0], run_length[7:0], bitmap_done,
//                               status[2:0]
// cfg      cfg_valid/cfg_ready  expected_pixels[14:0]
//
// One byte is taken per cycle while in_stall is low; its result (if any) is
// registered in the output register, or in the skid while the output stalls.
// The byte decode is combinational logic from the state register. A one-word
// skid register behind the output register lets input continue while a result
// waits; in_stall rises only when the skid holds a word. Reset clears decoder
// state, expected_pixels and the valid flags of both buffers.
module nibble_packbits_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  code_byte,
	input  wire logic        end_of_bitmap,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       pixel_value,
	output logic [7:0]       run_length,
	output logic             bitmap_done,
	output logic [2:0]       status,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [14:0] expected_pixels
);

	npb_pkg::dec_state_t state_q;
	npb_pkg::dec_state_t state_next;
	npb_pkg::pix_cnt_t   expected_q;
	npb_pkg::result_t    result;
	npb_pkg::result_t    out_q;
	npb_pkg::result_t    skid_q;
	logic                emit;
	logic                out_valid_q;
	logic                skid_valid_q;
	logic                accept;
	logic                emit_acc;
	logic                out_free;

	npb_step u_step (
		.state      (state_q),
		.code_byte  (code_byte),
		.last       (end_of_bitmap),
		.expected   (expected_q),
		.state_next (state_next),
		.emit       (emit),
		.result     (result)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_valid_q;
	assign accept    = in_valid && !skid_valid_q;
	assign emit_acc  = accept && emit;
	assign out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= npb_pkg::STATE_CLEAR;
			expected_q <= '0;
		end else begin
			if (accept)
				state_q <= state_next;
			if (cfg_valid)
				expected_q <= expected_pixels;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			// no input is taken while the skid is full
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= emit_acc;
			end
		end else if (emit_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (emit_acc)
				out_q <= result;
		end else if (emit_acc) begin
			skid_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_value = out_q.pixel_value;
	assign run_length  = out_q.run_length;
	assign bitmap_done = out_q.bitmap_done;
	assign status      = out_q.status;

endmodule

`default_nettype wire

// ===== hdl/npb_step.sv =====
`default_nettype none

// Next-state and result logic for one encoded byte.
module npb_step (
	input  wire npb_pkg::dec_state_t state,
	input  wire logic [7:0]          code_byte,
	input  wire logic                last,
	input  wire npb_pkg::pix_cnt_t   expected,
	output npb_pkg::dec_state_t      state_next,
	output logic                     emit,
	output npb_pkg::result_t         result
);

	npb_pkg::pix_cnt_t exp_c;
	npb_pkg::pix_cnt_t remaining;
	npb_pkg::pix_cnt_t done_rep;
	npb_pkg::pix_cnt_t done_lit;
	logic [7:0]        count;
	logic [7:0]        lit_dec;
	logic              bad_value;
	logic              overflow;

	assign exp_c     = (expected > npb_pkg::PIX_W'(npb_pkg::MAX_PIXELS)) ?
		npb_pkg::PIX_W'(npb_pkg::MAX_PIXELS) : expected;
	assign remaining = (exp_c > state.pixels_done) ? exp_c - state.pixels_done : '0;
	assign count     = {1'b0, code_byte[6:0]} + 8'd1;
	assign overflow  = npb_pkg::PIX_W'(count) > remaining;
	assign bad_value = code_byte[7:4] != 4'd0;
	assign done_rep  = state.pixels_done + npb_pkg::PIX_W'(state.repeat_count);
	assign done_lit  = state.pixels_done + npb_pkg::PIX_W'(1);
	assign lit_dec   = (state.literal_left != 8'd0) ? state.literal_left - 8'd1 : 8'd0;

	always_comb begin
		state_next = state;
		emit       = 1'b0;
		result     = '{pixel_value: 4'd0, run_length: 8'd0, bitmap_done: 1'b1,
			status: npb_pkg::ST_OK};

		if (state.dropping) begin
			if (last) begin
				emit          = 1'b1;
				result.status = state.first_error;
				state_next    = npb_pkg::STATE_CLEAR;
			end
		end else begin
			case (state.phase)
				npb_pkg::PH_REPEAT, npb_pkg::PH_LITERAL: begin
					if (bad_value) begin
						if (last) begin
							emit          = 1'b1;
							result.status = npb_pkg::ST_VALUE;
							state_next    = npb_pkg::STATE_CLEAR;
						end else begin
							state_next.dropping    = 1'b1;
							state_next.first_error = npb_pkg::ST_VALUE;
						end
					end else begin
						if (state.phase == npb_pkg::PH_REPEAT) begin
							state_next.pixels_done = done_rep;
							state_next.phase       = npb_pkg::PH_CTRL;
							result.run_length      = state.repeat_count;
						end else begin
							state_next.pixels_done  = done_lit;
							state_next.literal_left = lit_dec;
							if (lit_dec == 8'd0)
								state_next.phase = npb_pkg::PH_CTRL;
							result.run_length = 8'd1;
						end
						emit               = 1'b1;
						result.pixel_value = code_byte[3:0];
						result.bitmap_done = last;
						if (last) begin
							if (state_next.phase != npb_pkg::PH_CTRL)
								result.status = npb_pkg::ST_TRUNC;
							else if (state_next.pixels_done != exp_c)
								result.status = npb_pkg::ST_SHORT;
							state_next = npb_pkg::STATE_CLEAR;
						end
					end
				end
				default: begin
					// control byte; also covers the unused phase code
					if (overflow || last) begin
						if (last) begin
							emit          = 1'b1;
							result.status = overflow ? npb_pkg::ST_OVERFLOW : npb_pkg::ST_TRUNC;
							state_next    = npb_pkg::STATE_CLEAR;
						end else begin
							state_next.dropping    = 1'b1;
							state_next.first_error = npb_pkg::ST_OVERFLOW;
						end
					end else if (code_byte[7]) begin
						state_next.repeat_count = count;
						state_next.phase        = npb_pkg::PH_REPEAT;
					end else begin
						state_next.literal_left = count;
						state_next.phase        = npb_pkg::PH_LITERAL;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire
